// File: design/emt_pkg.sv
// Package of the encoder multi-turn tracker.
// Holds register indexes, error codes, datapath opcodes and the command/status types.
// No dependencies.
`timescale 1ns / 1ps

package emt_pkg;

	localparam int ANGLE_BITS_DEF = 14;
	localparam int TURN_BITS_DEF  = 16;
	localparam int CFG_W          = 31;

	// Configuration register indexes
	localparam logic [2:0] REG_DIRECTION = 3'd0;
	localparam logic [2:0] REG_OFFSET    = 3'd1;
	localparam logic [2:0] REG_CAL       = 3'd2;
	localparam logic [2:0] REG_MAX_JUMP  = 3'd3;
	localparam logic [2:0] REG_GAIN_PROP = 3'd4;
	localparam logic [2:0] REG_GAIN_INT  = 3'd5;
	localparam logic [2:0] REG_MIN_IVL   = 3'd6;

	// Decoded error codes
	localparam logic [1:0] ERR_NONE    = 2'd0;
	localparam logic [1:0] ERR_FRAMING = 2'd1;
	localparam logic [1:0] ERR_COMMAND = 2'd2;
	localparam logic [1:0] ERR_PARITY  = 2'd3;

	// Microseconds per second and the saturation cap of scaled terms
	localparam logic [19:0] US_PER_S = 20'd1000000;
	localparam logic [63:0] CAP62    = 64'h4000_0000_0000_0000;

	// Datapath operations
	localparam logic [3:0] OP_NONE   = 4'd0;
	localparam logic [3:0] OP_LOAD   = 4'd1;
	localparam logic [3:0] OP_EVAL   = 4'd2;
	localparam logic [3:0] OP_ORIENT = 4'd3;
	localparam logic [3:0] OP_TRACK  = 4'd4;
	localparam logic [3:0] OP_ERR    = 4'd5;
	localparam logic [3:0] OP_MUL1   = 4'd6;
	localparam logic [3:0] OP_MUL2   = 4'd7;
	localparam logic [3:0] OP_INTEG  = 4'd8;
	localparam logic [3:0] OP_OMEGA  = 4'd9;
	localparam logic [3:0] OP_EST    = 4'd10;
	localparam logic [3:0] OP_OUT    = 4'd11;

	typedef struct packed {
		logic [3:0] op;
		logic       sc_start;
		logic       sc_sel;
	} dp_cmd_t;

	typedef struct packed {
		logic abort;
		logic observe;
		logic sc_done;
	} dp_sts_t;

endpackage

// File: design/emt_scale.sv
// Iterative scaling unit: q = min(floor(m * dt / 1e6), 2^62).
// Two partial products on one shared 32x32 multiplier, then eight 12-bit quotient digits
// by reciprocal multiplication, each a digit step and a remainder step. Depends on emt_pkg.
`timescale 1ns / 1ps

module emt_scale
	import emt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] m,
	input  logic [31:0] dt,
	output logic        done,
	output logic [62:0] q
);

	localparam logic [1:0] P_IDLE = 2'd0;
	localparam logic [1:0] P_MUL  = 2'd1;
	localparam logic [1:0] P_DIV  = 2'd2;
	localparam logic [1:0] P_FIN  = 2'd3;

	// One million's reciprocal scaled by 2^50; the quotient is exact for any 32-bit dividend.
	localparam logic [31:0] RECIP_US = 32'h431B_DE83;

	logic [1:0]  phase_q;
	logic [2:0]  cnt_q;
	logic        sub_q;
	logic [95:0] acc_q;
	logic [63:0] m_q;
	logic [31:0] dt_q;
	logic [19:0] rem_q;
	logic [11:0] dig_q;
	logic [62:0] q_q;
	logic        done_q;

	logic [31:0] num;
	logic [31:0] mul_a, mul_b;
	logic [63:0] mprod;
	logic [31:0] dprod;
	logic [31:0] rem_c;

	// The partial remainder and the next 12 product bits form the digit dividend.
	assign num   = {rem_q, acc_q[95:84]};
	// Shared multiplier: operand halves times dt, then the dividend times the reciprocal.
	assign mul_a = (phase_q == P_DIV) ? num : (cnt_q[0] ? m_q[31:0] : m_q[63:32]);
	assign mul_b = (phase_q == P_DIV) ? RECIP_US : dt_q;
	assign mprod = mul_a * mul_b;
	// Remainder after removing the digit's multiple of one million.
	assign dprod = {20'd0, dig_q} * {12'd0, US_PER_S};
	assign rem_c = num - dprod;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= P_IDLE;
			cnt_q   <= '0;
			sub_q   <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (phase_q)
				P_IDLE: begin
					if (start) begin
						phase_q <= P_MUL;
						cnt_q   <= 3'd1;
					end
				end
				P_MUL: begin
					if (cnt_q == 3'd0) begin
						phase_q <= P_DIV;
						cnt_q   <= 3'd7;
						sub_q   <= 1'b0;
					end else begin
						cnt_q <= cnt_q - 3'd1;
					end
				end
				P_DIV: begin
					sub_q <= ~sub_q;
					if (sub_q) begin
						if (cnt_q == 3'd0)
							phase_q <= P_FIN;
						else
							cnt_q <= cnt_q - 3'd1;
					end
				end
				P_FIN: begin
					phase_q <= P_IDLE;
					done_q  <= 1'b1;
				end
				default: phase_q <= P_IDLE;
			endcase
		end
	end

	// Operand, product/quotient, digit and remainder registers
	always_ff @(posedge clk) begin
		unique case (phase_q)
			P_IDLE: begin
				if (start) begin
					m_q   <= m;
					dt_q  <= dt;
					rem_q <= '0;
				end
			end
			P_MUL: begin
				if (cnt_q[0])
					acc_q <= {32'd0, mprod};
				else
					acc_q <= acc_q + {mprod, 32'd0};
			end
			P_DIV: begin
				if (!sub_q) begin
					dig_q <= mprod[61:50];
				end else begin
					rem_q <= rem_c[19:0];
					acc_q <= {acc_q[83:0], dig_q};
				end
			end
			P_FIN: begin
				q_q <= (acc_q > {32'd0, CAP62}) ? CAP62[62:0] : acc_q[62:0];
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign q    = q_q;

endmodule

// File: design/emt_dp.sv
// Datapath of the encoder multi-turn tracker: configuration, tracking state,
// unwrap arithmetic, PI observer registers and the result register.
// Depends on emt_pkg and emt_scale.
`timescale 1ns / 1ps

module emt_dp
	import emt_pkg::*;
#(
	parameter int ANGLE_BITS = ANGLE_BITS_DEF,
	parameter int TURN_BITS  = TURN_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  dp_cmd_t          cmd,
	output dp_sts_t          sts,
	input  logic [55:0]      in_data,
	input  logic             cfg_we,
	input  logic [2:0]       cfg_idx,
	input  logic [CFG_W-1:0] cfg_data,
	output logic [111:0]     out_data,
	output logic [2:0]       out_user
);

	localparam int HALF_TURN = 1 << (ANGLE_BITS - 1);

	// Configuration
	logic        dir_q, cal_q;
	logic [30:0] offset_q;
	logic [29:0] maxj_q;
	logic [15:0] gp_q, gi_q, miniv_q;

	// Captured request
	logic [15:0] frame_q;
	logic [2:0]  ew_q;
	logic [31:0] now_q;

	// Tracking and observer state
	logic [ANGLE_BITS-1:0] last_raw_q;
	logic [TURN_BITS-1:0]  turns_q;
	logic [31:0]           last_abs_q, vel_q, last_time_q;
	logic [47:0]           est_q, integ_q;
	logic [15:0]           pcnt_q, fcnt_q, jcnt_q;

	// Working registers
	logic [1:0]  code_q;
	logic        obs_q, e_neg_q;
	logic [31:0] a_q, dt_q;
	logic [47:0] em_q, omega_q;
	logic [63:0] m1_q, pm_q;

	// Result register
	logic [31:0] o_abs_q, o_vel_q;
	logic [1:0]  o_code_q;
	logic        o_acc_q;
	logic [15:0] o_p_q, o_f_q, o_j_q;

	logic [1:0]                 code_c;
	logic [ANGLE_BITS-1:0]      raw;
	logic signed [ANGLE_BITS:0] d;
	logic [63:0]                t64, u;
	logic [31:0]                diff, dmag;
	logic [47:0]                e48, om;
	logic [63:0]                prod;
	logic [64:0]                integ_sum, omega_sum, pterm, t1s;
	logic [47:0]                t2s;
	logic [32:0]                vm;
	logic [31:0]                vel_c;
	logic                       sc_done;
	logic [62:0]                sc_q;
	logic [63:0]                sc_m;

	function automatic logic [47:0] sat48(input logic [64:0] v);
		logic signed [64:0] s;
		begin
			s = $signed(v);
			if (s > 65'sh0_7FFF_FFFF_FFFF)
				sat48 = 48'h7FFF_FFFF_FFFF;
			else if (s < -65'sh0_8000_0000_0000)
				sat48 = 48'h8000_0000_0000;
			else
				sat48 = v[47:0];
		end
	endfunction

	// Error decode, parity > command > framing
	always_comb begin
		code_c = ERR_NONE;
		if (frame_q[14]) begin
			priority if (ew_q[2]) code_c = ERR_PARITY;
			else if (ew_q[1]) code_c = ERR_COMMAND;
			else if (ew_q[0]) code_c = ERR_FRAMING;
			else code_c = ERR_NONE;
		end
	end

	// Unwrap, orientation and jump arithmetic
	assign raw  = frame_q[ANGLE_BITS-1:0];
	assign d    = $signed({1'b0, raw}) - $signed({1'b0, last_raw_q});
	assign t64  = {{(64-TURN_BITS){turns_q[TURN_BITS-1]}}, turns_q};
	always_comb begin
		u = (t64 << ANGLE_BITS) + 64'(raw);
		if (dir_q)
			u = 64'd0 - u;
		u = u - {{33{offset_q[30]}}, offset_q};
	end
	assign diff = a_q - last_abs_q;
	assign dmag = diff[31] ? 32'd0 - diff : diff;

	// Observer arithmetic
	assign e48       = {a_q, 16'h0000} - est_q;
	assign prod      = em_q * ((cmd.op == OP_MUL1) ? gi_q : gp_q);
	assign t1s       = e_neg_q ? 65'd0 - {2'b00, sc_q} : {2'b00, sc_q};
	assign integ_sum = {{17{integ_q[47]}}, integ_q} + t1s;
	assign pterm     = e_neg_q ? 65'd0 - {1'b0, pm_q} : {1'b0, pm_q};
	assign omega_sum = pterm + {{17{integ_q[47]}}, integ_q};
	assign om        = omega_q[47] ? 48'd0 - omega_q : omega_q;
	assign t2s       = omega_q[47] ? 48'd0 - sc_q[47:0] : sc_q[47:0];
	assign vm        = 33'(({1'b0, om} + 49'h8000) >> 16);
	always_comb begin
		if (omega_q[47])
			vel_c = 32'd0 - vm[31:0];
		else if (vm > 33'h0_7FFF_FFFF)
			vel_c = 32'h7FFF_FFFF;
		else
			vel_c = vm[31:0];
	end

	assign sc_m = cmd.sc_sel ? {16'd0, om} : m1_q;

	emt_scale u_scale (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.sc_start),
		.m      (sc_m),
		.dt     (dt_q),
		.done   (sc_done),
		.q      (sc_q)
	);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q    <= 1'b1;
			offset_q <= '0;
			cal_q    <= 1'b0;
			maxj_q   <= 30'd1024;
			gp_q     <= 16'd100;
			gi_q     <= 16'd300;
			miniv_q  <= 16'd100;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_DIRECTION: dir_q    <= cfg_data[0];
				REG_OFFSET:    offset_q <= cfg_data[30:0];
				REG_CAL:       cal_q    <= cfg_data[0];
				REG_MAX_JUMP:  maxj_q   <= cfg_data[29:0];
				REG_GAIN_PROP: gp_q     <= cfg_data[15:0];
				REG_GAIN_INT:  gi_q     <= cfg_data[15:0];
				REG_MIN_IVL:   miniv_q  <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Tracking and observer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_raw_q  <= '0;
			turns_q     <= '0;
			last_abs_q  <= '0;
			vel_q       <= '0;
			last_time_q <= '0;
			est_q       <= '0;
			integ_q     <= '0;
			pcnt_q      <= '0;
			fcnt_q      <= '0;
			jcnt_q      <= '0;
			code_q      <= ERR_NONE;
			obs_q       <= 1'b0;
		end else begin
			unique case (cmd.op)
				OP_EVAL: begin
					if ((^frame_q[14:0]) != frame_q[15])
						pcnt_q <= pcnt_q + 16'd1;
					if (frame_q[14])
						fcnt_q <= fcnt_q + 16'd1;
					code_q <= code_c;
					if (code_c == ERR_NONE) begin
						if (d > HALF_TURN)
							turns_q <= turns_q - TURN_BITS'(1);
						else if (d < -HALF_TURN)
							turns_q <= turns_q + TURN_BITS'(1);
						last_raw_q <= raw;
					end
				end
				OP_TRACK: begin
					if (dmag > {2'b00, maxj_q})
						jcnt_q <= jcnt_q + 16'd1;
					last_abs_q <= a_q;
					obs_q      <= 1'b0;
					if (dt_q > {16'd0, miniv_q}) begin
						last_time_q <= now_q;
						obs_q       <= cal_q;
					end
				end
				OP_INTEG: integ_q <= sat48(integ_sum);
				OP_EST: begin
					est_q <= est_q + t2s;
					vel_q <= vel_c;
				end
				default: ;
			endcase
		end
	end

	// Captured request, working and result registers
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				frame_q <= in_data[15:0];
				ew_q    <= in_data[18:16];
				now_q   <= in_data[50:19];
			end
			OP_EVAL:   dt_q <= now_q - last_time_q;
			OP_ORIENT: a_q  <= u[31:0];
			OP_ERR: begin
				e_neg_q <= e48[47];
				em_q    <= e48[47] ? 48'd0 - e48 : e48;
			end
			OP_MUL1:  m1_q <= prod;
			OP_MUL2:  pm_q <= (prod > CAP62) ? CAP62 : prod;
			OP_OMEGA: omega_q <= sat48(omega_sum);
			OP_OUT: begin
				o_abs_q  <= last_abs_q;
				o_vel_q  <= vel_q;
				o_code_q <= code_q;
				o_acc_q  <= (code_q == ERR_NONE);
				o_p_q    <= pcnt_q;
				o_f_q    <= fcnt_q;
				o_j_q    <= jcnt_q;
			end
			default: ;
		endcase
	end

	assign sts.abort   = (code_q != ERR_NONE);
	assign sts.observe = obs_q;
	assign sts.sc_done = sc_done;

	assign out_data = {o_j_q, o_f_q, o_p_q, o_vel_q, o_abs_q};
	assign out_user = {o_acc_q, o_code_q};

endmodule

// File: design/emt_ctrl.sv
// Controller of the encoder multi-turn tracker: sequences the datapath per request
// and owns the stream handshakes.
// Depends on emt_pkg.
`timescale 1ns / 1ps

module emt_ctrl
	import emt_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_tvalid,
	output logic    s_tready,
	output logic    m_tvalid,
	input  logic    m_tready,
	output dp_cmd_t cmd,
	input  dp_sts_t sts
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_EVAL   = 4'd1;
	localparam logic [3:0] S_ORIENT = 4'd2;
	localparam logic [3:0] S_TRACK  = 4'd3;
	localparam logic [3:0] S_OBS    = 4'd4;
	localparam logic [3:0] S_ERR    = 4'd5;
	localparam logic [3:0] S_MUL1   = 4'd6;
	localparam logic [3:0] S_MUL2   = 4'd7;
	localparam logic [3:0] S_SC1    = 4'd8;
	localparam logic [3:0] S_INTEG  = 4'd9;
	localparam logic [3:0] S_OMEGA  = 4'd10;
	localparam logic [3:0] S_START2 = 4'd11;
	localparam logic [3:0] S_SC2    = 4'd12;
	localparam logic [3:0] S_EST    = 4'd13;
	localparam logic [3:0] S_OUT    = 4'd14;

	logic [3:0] state_q, state_d;
	logic       mvalid_q;

	// Next state and datapath command
	always_comb begin
		state_d      = state_q;
		cmd.op       = OP_NONE;
		cmd.sc_start = 1'b0;
		cmd.sc_sel   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.op  = OP_LOAD;
					state_d = S_EVAL;
				end
			end
			S_EVAL: begin
				cmd.op  = OP_EVAL;
				state_d = S_ORIENT;
			end
			S_ORIENT: begin
				if (sts.abort) begin
					state_d = S_OUT;
				end else begin
					cmd.op  = OP_ORIENT;
					state_d = S_TRACK;
				end
			end
			S_TRACK: begin
				cmd.op  = OP_TRACK;
				state_d = S_OBS;
			end
			S_OBS: state_d = sts.observe ? S_ERR : S_OUT;
			S_ERR: begin
				cmd.op  = OP_ERR;
				state_d = S_MUL1;
			end
			S_MUL1: begin
				cmd.op  = OP_MUL1;
				state_d = S_MUL2;
			end
			S_MUL2: begin
				cmd.op       = OP_MUL2;
				cmd.sc_start = 1'b1;
				state_d      = S_SC1;
			end
			S_SC1: begin
				if (sts.sc_done)
					state_d = S_INTEG;
			end
			S_INTEG: begin
				cmd.op  = OP_INTEG;
				state_d = S_OMEGA;
			end
			S_OMEGA: begin
				cmd.op  = OP_OMEGA;
				state_d = S_START2;
			end
			S_START2: begin
				cmd.sc_start = 1'b1;
				cmd.sc_sel   = 1'b1;
				state_d      = S_SC2;
			end
			S_SC2: begin
				cmd.sc_sel = 1'b1;
				if (sts.sc_done)
					state_d = S_EST;
			end
			S_EST: begin
				cmd.op  = OP_EST;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (!mvalid_q || m_tready) begin
					cmd.op  = OP_OUT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State and result-valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			mvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.op == OP_OUT)
				mvalid_q <= 1'b1;
			else if (m_tready)
				mvalid_q <= 1'b0;
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = mvalid_q;

endmodule

// File: design/encoder_multiturn_tracker.sv
// Sequence: an aborted frame goes from load through evaluate and orient to the result; an
// accepted frame without a velocity instant also passes track and observe; one with an
// instant adds the observer steps and two passes of the scaling unit (multiply, divide, saturate).
// Requests: the next request is taken the cycle after the result is loaded, even while
// it waits; a result still waiting stalls the next one.
// Reset: arst_n clears all tracking state and counters and loads the register defaults.
`timescale 1ns / 1ps

module encoder_multiturn_tracker
	import emt_pkg::*;
#(
	parameter int ANGLE_BITS = ANGLE_BITS_DEF,
	parameter int TURN_BITS  = TURN_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	// angle_frame[15:0], error_word[18:16], time_us[50:19], zero fill
	input  logic [55:0]      s_tdata,
	output logic             m_tvalid,
	input  logic             m_tready,
	// abs_angle[31:0], velocity[63:32], parity_fail_count[79:64],
	// flag_count[95:80], jump_count[111:96]
	output logic [111:0]     m_tdata,
	// error_code[1:0], accepted[2]
	output logic [2:0]       m_tuser,
	input  logic             cfg_we,
	input  logic [2:0]       cfg_idx,
	input  logic [CFG_W-1:0] cfg_data
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	emt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	emt_dp #(
		.ANGLE_BITS (ANGLE_BITS),
		.TURN_BITS  (TURN_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.in_data  (s_tdata),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.out_data (m_tdata),
		.out_user (m_tuser)
	);

endmodule

// File: design/emt_checker.sv
// Port-level checker of the encoder multi-turn tracker, bound to the top level.
// Depends on emt_pkg.
`timescale 1ns / 1ps

module emt_checker
	import emt_pkg::*;
(
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [111:0] m_tdata,
	input logic [2:0]   m_tuser
);

	// No result is shown once reset has been held for a clock edge.
	a_reset_quiet: assert property (@(posedge clk) !arst_n && $past(!arst_n) |-> !m_tvalid)
		else $error("result valid during reset");

	// A stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	// A result is accepted exactly when no error was decoded.
	a_acc_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser[2] == (m_tuser[1:0] == ERR_NONE)))
		else $error("accepted flag disagrees with error code");

	// One request at a time: no request is taken right after another.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while busy");

endmodule

bind encoder_multiturn_tracker emt_checker u_emt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

// File: tb/encoder_multiturn_tracker_tb.sv
// Self-checking testbench of encoder_multiturn_tracker: directed and random angle requests
// checked against an in-bench predictor of unwrap, counters and the PI velocity observer.
// Depends on emt_pkg and the design sources only.
`timescale 1ns / 1ps

module encoder_multiturn_tracker_tb;
	import emt_pkg::*;

	localparam int MAX_REPORTS = 10;
	localparam longint unsigned USEC = 64'd1000000;
	localparam longint unsigned CAP = 64'h4000_0000_0000_0000;
	localparam longint signed HI48 = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint signed LO48 = -64'sh0000_8000_0000_0000;

	// Expected content of one tracker result.
	typedef struct {
		logic [31:0] abs_angle;
		logic [31:0] velocity;
		logic [1:0]  error_code;
		logic        accepted;
		logic [15:0] parity_cnt;
		logic [15:0] flag_cnt;
		logic [15:0] jump_cnt;
	} track_result_t;

	// Tracker predictor and the queue of results still owed by the block.
	class tracker_scoreboard;
		bit [0:0]  dir_ccw;
		bit [30:0] offset;
		bit [0:0]  cal;
		bit [29:0] jump_lim;
		bit [15:0] kp, ki, ivl;
		bit [13:0] prev_raw;
		bit [15:0] turn_cnt;
		bit [31:0] prev_abs, held_vel, prev_time;
		longint signed est, integ;
		bit [15:0] par_errs, flag_errs, jump_errs;
		track_result_t owed[$];
		int mismatches;
		int checked;
		int instants;

		function new();
			dir_ccw = 1; offset = 0; cal = 0; jump_lim = 1024;
			kp = 100; ki = 300; ivl = 100;
			prev_raw = 0; turn_cnt = 0; prev_abs = 0; held_vel = 0; prev_time = 0;
			est = 0; integ = 0;
			par_errs = 0; flag_errs = 0; jump_errs = 0;
			mismatches = 0; checked = 0; instants = 0;
		endfunction

		function void apply_config(logic [2:0] idx, logic [CFG_W-1:0] val);
			case (idx)
				REG_DIRECTION: dir_ccw = val[0];
				REG_OFFSET:    offset = val[30:0];
				REG_CAL:       cal = val[0];
				REG_MAX_JUMP:  jump_lim = val[29:0];
				REG_GAIN_PROP: kp = val[15:0];
				REG_GAIN_INT:  ki = val[15:0];
				REG_MIN_IVL:   ivl = val[15:0];
				default: ;
			endcase
		endfunction

		// Sign extension of the low bits of a 64-bit word.
		function longint signed sx(longint unsigned v, int bits);
			longint unsigned sb;
			sb = 64'd1 << (bits - 1);
			v &= (sb << 1) - 1;
			return longint'(v ^ sb) - longint'(sb);
		endfunction

		function longint unsigned magnitude(longint signed v);
			return v < 0 ? 64'd0 - longint'(v) : v;
		endfunction

		function longint signed clip48(longint signed v);
			return v > HI48 ? HI48 : (v < LO48 ? LO48 : v);
		endfunction

		// floor(m * dt / 1e6) with the 2^62 cap, split to avoid overflow.
		function longint unsigned time_scale(longint unsigned m, bit [31:0] dt);
			longint unsigned q, r, hi, lo;
			q = m / USEC;
			r = m % USEC;
			if (dt != 0 && q > CAP / dt) return CAP;
			hi = q * dt;
			lo = (r * dt) / USEC;
			return (hi + lo > CAP) ? CAP : hi + lo;
		endfunction

		function longint signed signed_time_scale(longint signed s, longint unsigned m,
				bit [31:0] dt);
			longint signed r;
			r = time_scale(m, dt);
			return s < 0 ? -r : r;
		endfunction

		// One PI observer update; returns the new velocity in counts per second.
		function bit [31:0] observer_step(bit [31:0] angle, bit [31:0] dt);
			longint unsigned aq, em, pm, om, vm;
			longint signed e, pterm, omega;
			aq = longint'(sx(angle, 32)) << 16;
			e = sx(aq - est, 48);
			em = magnitude(e);
			integ = clip48(integ + signed_time_scale(e, em * ki, dt));
			pm = em * kp;
			if (pm > CAP) pm = CAP;
			pterm = e < 0 ? -longint'(pm) : longint'(pm);
			omega = clip48(pterm + integ);
			est = sx(est + signed_time_scale(omega, magnitude(omega), dt), 48);
			om = magnitude(omega);
			vm = (om + 64'h8000) >> 16;
			if (omega < 0) vm = 64'd0 - vm;
			else if (vm > 64'h7FFF_FFFF) vm = 64'h7FFF_FFFF;
			return vm[31:0];
		endfunction

		// Predict the result of one accepted request and queue it.
		function void note_request(bit [15:0] frame, bit [2:0] ew, bit [31:0] now);
			track_result_t r;
			bit [1:0] code;
			bit [31:0] a, diff, dmag, dt;
			int d;
			longint unsigned u;
			code = ERR_NONE;
			if (^frame[14:0] != frame[15]) par_errs++;
			if (frame[14]) begin
				flag_errs++;
				code = ew[2] ? ERR_PARITY : ew[1] ? ERR_COMMAND : ew[0] ? ERR_FRAMING : ERR_NONE;
			end
			r.accepted = 0;
			if (code == ERR_NONE) begin
				d = int'(frame[13:0]) - int'(prev_raw);
				if (d > 8192) turn_cnt--;
				else if (d < -8192) turn_cnt++;
				prev_raw = frame[13:0];
				u = (longint'(sx(turn_cnt, 16)) << 14) + frame[13:0];
				if (dir_ccw) u = 64'd0 - u;
				u -= sx(offset, 31);
				a = u[31:0];
				diff = a - prev_abs;
				dmag = diff[31] ? 32'd0 - diff : diff;
				if (dmag > jump_lim) jump_errs++;
				prev_abs = a;
				dt = now - prev_time;
				if (dt > ivl) begin
					if (cal) begin
						held_vel = observer_step(a, dt);
						instants++;
					end
					prev_time = now;
				end
				r.accepted = 1;
			end
			r.abs_angle = prev_abs;
			r.velocity = held_vel;
			r.error_code = code;
			r.parity_cnt = par_errs;
			r.flag_cnt = flag_errs;
			r.jump_cnt = jump_errs;
			owed.push_back(r);
		endfunction

		function void report(string what, logic [31:0] want, logic [31:0] got);
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("mismatch on result %0d, %s: expected %h, got %h",
					checked, what, want, got);
		endfunction

		// Compare one result with the oldest expectation.
		function void check_result(logic [111:0] data, logic [2:0] user);
			track_result_t r;
			if (owed.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected result: data %h user %h", data, user);
				return;
			end
			r = owed.pop_front();
			if (data[31:0] !== r.abs_angle) report("abs_angle", r.abs_angle, data[31:0]);
			if (data[63:32] !== r.velocity) report("velocity", r.velocity, data[63:32]);
			if (data[79:64] !== r.parity_cnt) report("parity count", r.parity_cnt, data[79:64]);
			if (data[95:80] !== r.flag_cnt) report("flag count", r.flag_cnt, data[95:80]);
			if (data[111:96] !== r.jump_cnt) report("jump count", r.jump_cnt, data[111:96]);
			if (user[1:0] !== r.error_code) report("error_code", r.error_code, user[1:0]);
			if (user[2] !== r.accepted) report("accepted", r.accepted, user[2]);
			checked++;
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [55:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [111:0] m_tdata;
	logic [2:0] m_tuser;
	logic cfg_we;
	logic [2:0] cfg_idx;
	logic [CFG_W-1:0] cfg_data;

	tracker_scoreboard sb;
	bit [13:0] cur_raw;
	bit [31:0] cur_time;
	int burst_left;
	int sent;

	encoder_multiturn_tracker dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// Run limit, well beyond the slowest correct run.
	initial begin
		#20ms;
		$display("CHECKS FAILED");
		$finish;
	end

	// Receiver: stalls in runs, with long stretches of steady acceptance.
	initial begin
		int mode;
		m_tready = 0;
		@(posedge arst_n);
		forever begin
			mode = $urandom_range(0, 3);
			repeat ($urandom_range(1, 40)) begin
				@(posedge clk);
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= ($urandom_range(0, 3) != 0);
					2: m_tready <= ($urandom_range(0, 3) == 0);
					default: m_tready <= 1'b0;
				endcase
			end
		end
	end

	// Result monitor.
	always @(posedge clk)
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tuser);

	task automatic cfg_write(logic [2:0] idx, logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		sb.apply_config(idx, val);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Wait until every owed result has come, then let the block settle.
	task automatic drain();
		if (s_tvalid) begin
			@(posedge clk);
			s_tvalid <= 1'b0;
		end
		while (sb.owed.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	// Send one request; between bursts the sender idles for a random gap.
	task automatic send(bit [15:0] frame, bit [2:0] ew, bit [31:0] t);
		int gap;
		gap = 0;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
			burst_left = $urandom_range(1, 20);
		end
		@(posedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {5'd0, t, ew, frame};
		do @(posedge clk); while (!s_tready);
		sb.note_request(frame, ew, t);
		burst_left--;
		sent++;
	endtask

	function automatic bit [15:0] make_frame(bit [13:0] raw, bit flag, bit good_par);
		bit p;
		p = ^{flag, raw};
		return {good_par ? p : ~p, flag, raw};
	endfunction

	// Well-formed requests mostly; flagged, bad-parity and wild ones as noise.
	task automatic random_request(int ivl);
		bit flag;
		bit good;
		int step;
		flag = ($urandom_range(0, 9) == 0);
		good = ($urandom_range(0, 19) != 0);
		case ($urandom_range(0, 9))
			0: cur_raw = 14'($urandom);
			1: step = $urandom_range(0, 16383) - 8192;
			default: step = $urandom_range(0, 1200) - 600;
		endcase
		if (step != 0) cur_raw = 14'(int'(cur_raw) + step);
		step = 0;
		if ($urandom_range(0, 49) == 0) cur_time = $urandom;
		else cur_time = cur_time + $urandom_range(0, 2 * ivl + 20);
		send(make_frame(cur_raw, flag, good), 3'($urandom_range(0, 7)), cur_time);
	endtask

	task automatic set_all(bit dir, logic [30:0] off, bit cal, logic [29:0] jl,
			logic [15:0] kp, logic [15:0] ki, logic [15:0] ivl);
		cfg_write(REG_DIRECTION, dir);
		cfg_write(REG_OFFSET, off);
		cfg_write(REG_CAL, cal);
		cfg_write(REG_MAX_JUMP, jl);
		cfg_write(REG_GAIN_PROP, kp);
		cfg_write(REG_GAIN_INT, ki);
		cfg_write(REG_MIN_IVL, ivl);
	endtask

	initial begin
		int ivl;
		sb = new();
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = '0;
		cfg_we = 0;
		cfg_idx = '0;
		cfg_data = '0;
		cur_raw = 0;
		cur_time = 0;
		burst_left = 0;
		sent = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed, first with reset settings: angle extremes, the half-turn step, every error
		// word with the flag, and bad parity both alone and with the flag.
		send(make_frame(14'h0000, 0, 1), 3'd0, 32'd50);
		send(make_frame(14'h3FFF, 0, 1), 3'd0, 32'd200);
		send(make_frame(14'h0000, 0, 1), 3'd0, 32'd400);
		send(make_frame(14'h2000, 0, 1), 3'd0, 32'd600);
		send(make_frame(14'h0000, 0, 1), 3'd0, 32'd800);
		for (int e = 0; e < 8; e++)
			send(make_frame(14'h1234, 1, 1), e[2:0], 32'd900 + e);
		send(make_frame(14'h1300, 0, 0), 3'd7, 32'd1200);
		send(make_frame(14'h1400, 1, 0), 3'd4, 32'd1300);
		drain();

		// The same with the observer on, across a timestamp wrap.
		set_all(0, 31'd0, 1, 30'd1024, 16'd100, 16'd300, 16'd100);
		send(make_frame(14'h0100, 0, 1), 3'd0, 32'hFFFF_FF00);
		send(make_frame(14'h0300, 0, 1), 3'd0, 32'hFFFF_FFF0);
		send(make_frame(14'h0500, 0, 1), 3'd0, 32'h0000_0100);
		send(make_frame(14'h3F00, 0, 1), 3'd0, 32'h0000_0200);
		send(make_frame(14'h0100, 0, 1), 3'd2, 32'h0000_0400);
		send(make_frame(14'h0200, 1, 1), 3'd0, 32'h0000_0600);
		drain();

		// Random phases, the register extremes among them.
		for (int p = 0; p < 6; p++) begin
			case (p)
				0: set_all(0, 31'd0, 1, 30'd1024, 16'd100, 16'd300, 16'd100);
				1: set_all(1, 31'h4000_0000, 1, 30'd0, 16'hFFFF, 16'hFFFF, 16'd0);
				2: set_all(0, 31'h3FFF_FFFF, 1, 30'h3FFF_FFFF, 16'd0, 16'd0, 16'hFFFF);
				3: set_all(1'b1, 31'($urandom), 1'b0, 30'($urandom_range(0, 8192)),
					16'($urandom), 16'($urandom), 16'($urandom_range(0, 500)));
				default: set_all(1'($urandom_range(0, 1)), 31'($urandom), 1'b1,
					30'($urandom_range(0, 4096)), 16'($urandom), 16'($urandom),
					16'($urandom_range(0, 300)));
			endcase
			ivl = sb.ivl;
			if (ivl > 2000 && p != 2) ivl = 2000;
			repeat (260) random_request(ivl);
			drain();
		end

		$display("Sent %0d angle requests over eight register settings; %0d results checked,",
			sent, sb.checked);
		$display("%0d of them with a velocity observer update.", sb.instants);
		if (sb.mismatches == 0 && sb.owed.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatches, %0d results missing", sb.mismatches, sb.owed.size());
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// File: filelist.f
design/emt_pkg.sv
design/emt_scale.sv
design/emt_dp.sv
design/emt_ctrl.sv
design/encoder_multiturn_tracker.sv
design/emt_checker.sv
tb/encoder_multiturn_tracker_tb.sv
